// ===== rtl/core/quorum_frame_aggregator_core_macros.svh =====
// Assertion macros for the frame aggregator core and its checker.
// Depends on nothing; a clk_i and rst_ni must be visible where it is used.
`ifndef QUORUM_FRAME_AGGREGATOR_CORE_MACROS_SVH
`define QUORUM_FRAME_AGGREGATOR_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define QFA_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("qfa assertion failed");

// Next-cycle implication, disabled while reset is held.
`define QFA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("qfa assertion failed");

`endif

// ===== rtl/core/qfa_pkg.sv =====
// Package of the frame aggregator core: word types, codes and sizes.
// Used by every module of the core; depends on nothing.
package qfa_pkg;

  localparam int unsigned MAX_WORKERS       = 16;
  localparam int unsigned TABLE_DEPTH_DEF   = 16;
  localparam int unsigned RESULT_LIMIT      = 16;
  localparam int unsigned CFG_IDX_W         = 3;
  localparam int unsigned CFG_DATA_W        = 16;

  typedef enum logic [1:0] {
    MODE_PARTIAL   = 2'd0,
    MODE_HEARTBEAT = 2'd1,
    MODE_TICK      = 2'd2,
    MODE_FLUSH     = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    REG_WORKER_COUNT   = 3'd0,
    REG_QUORUM_SIZE    = 3'd1,
    REG_TIMEOUT_TICKS  = 3'd2,
    REG_MAX_PENDING    = 3'd3,
    REG_DEAD_THRESHOLD = 3'd4
  } cfg_reg_e;

  typedef enum logic [1:0] {
    RD_ZERO = 2'd0,
    RD_SCAN = 2'd1,
    RD_CHK  = 2'd2
  } rd_sel_e;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] frame_number;
    logic [3:0]  worker_index;
    logic [62:0] capture_time;
  } in_word_t;

  typedef struct packed {
    logic [31:0] out_frame;
    logic [62:0] out_time;
    logic [15:0] contributor_mask;
    logic [4:0]  contributor_count;
    logic        quorum_ok;
    logic        expired;
    logic [4:0]  alive_workers;
    logic [31:0] released_total;
    logic [31:0] expired_total;
    logic        last;
  } out_word_t;

  typedef struct packed {
    logic    load;
    logic    upd;
    logic    alloc;
    logic    heart;
    logic    age_inc;
    logic    scan_clr;
    logic    scan_inc;
    logic    rel;
    logic    exp;
    logic    push_last;
    rd_sel_e rd_sel;
  } dp_cmd_t;

  typedef struct packed {
    mode_e mode;
    logic  found;
    logic  dup;
    logic  full;
    logic  rd_met;
    logic  rd_expired;
    logic  scan_lt_len;
    logic  over_pending;
    logic  len_nz;
    logic  limit;
    logic  hold_v;
    logic  out_free;
  } dp_status_t;

endpackage

// ===== rtl/core/qfa_ctrl.sv =====
// Controller of the frame aggregator core: sequences each input word.
// Depends on qfa_pkg; drives qfa_datapath through dp_cmd_t.
module qfa_ctrl import qfa_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  dp_status_t st_i,
  output dp_cmd_t    cmd_o
);

  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_EXEC  = 9'b000000010,
    ST_ALLOC = 9'b000000100,
    ST_CHK   = 9'b000001000,
    ST_SCAN  = 9'b000010000,
    ST_TRIM  = 9'b000100000,
    ST_FLUSH = 9'b001000000,
    ST_REL   = 9'b010000000,
    ST_FIN   = 9'b100000000
  } state_e;

  state_e  state_q, state_d, ret_q, ret_d;
  rd_sel_e pos_q, pos_d;
  logic    exp_q, exp_d;

  always_comb begin
    state_d    = state_q;
    ret_d      = ret_q;
    pos_d      = pos_q;
    exp_d      = exp_q;
    cmd_o      = '0;
    cmd_o.rd_sel = RD_ZERO;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_EXEC;
        end
      end
      ST_EXEC: begin
        unique case (st_i.mode)
          MODE_PARTIAL: begin
            if (st_i.found) begin
              cmd_o.upd = 1'b1;
              state_d   = st_i.dup ? ST_FIN : ST_CHK;
            end else if (st_i.full) begin
              pos_d   = RD_ZERO;
              exp_d   = 1'b1;
              ret_d   = ST_ALLOC;
              state_d = ST_REL;
            end else begin
              state_d = ST_ALLOC;
            end
          end
          MODE_HEARTBEAT: begin
            cmd_o.heart = 1'b1;
            state_d     = ST_FIN;
          end
          MODE_TICK: begin
            cmd_o.age_inc  = 1'b1;
            cmd_o.scan_clr = 1'b1;
            state_d        = ST_SCAN;
          end
          default: state_d = ST_FLUSH;
        endcase
      end
      ST_ALLOC: begin
        cmd_o.alloc = 1'b1;
        state_d     = ST_CHK;
      end
      ST_CHK: begin
        cmd_o.rd_sel = RD_CHK;
        if (st_i.rd_met) begin
          pos_d   = RD_CHK;
          exp_d   = 1'b0;
          ret_d   = ST_FIN;
          state_d = ST_REL;
        end else begin
          state_d = ST_FIN;
        end
      end
      ST_SCAN: begin
        cmd_o.rd_sel = RD_SCAN;
        if (st_i.limit) begin
          state_d = ST_FIN;
        end else if (!st_i.scan_lt_len) begin
          state_d = ST_TRIM;
        end else if (st_i.rd_expired) begin
          pos_d   = RD_SCAN;
          exp_d   = 1'b1;
          ret_d   = ST_SCAN;
          state_d = ST_REL;
        end else begin
          cmd_o.scan_inc = 1'b1;
        end
      end
      ST_TRIM: begin
        if (!st_i.limit && st_i.over_pending) begin
          pos_d   = RD_ZERO;
          exp_d   = 1'b1;
          ret_d   = ST_TRIM;
          state_d = ST_REL;
        end else begin
          state_d = ST_FIN;
        end
      end
      ST_FLUSH: begin
        if (!st_i.limit && st_i.len_nz) begin
          pos_d   = RD_ZERO;
          exp_d   = 1'b1;
          ret_d   = ST_FLUSH;
          state_d = ST_REL;
        end else begin
          state_d = ST_FIN;
        end
      end
      ST_REL: begin
        cmd_o.rd_sel = pos_q;
        cmd_o.exp    = exp_q;
        if (!st_i.hold_v || st_i.out_free) begin
          cmd_o.rel = 1'b1;
          state_d   = ret_q;
        end
      end
      ST_FIN: begin
        if (!st_i.hold_v) begin
          state_d = ST_IDLE;
        end else if (st_i.out_free) begin
          cmd_o.push_last = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ret_q   <= ST_FIN;
      pos_q   <= RD_ZERO;
      exp_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      pos_q   <= pos_d;
      exp_q   <= exp_d;
    end
  end

endmodule

// ===== rtl/core/qfa_datapath.sv =====
// Datapath of the frame aggregator core: frame table, worker health,
// counters, configuration and the result registers. Depends on qfa_pkg.
module qfa_datapath import qfa_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  in_word_t              in_data_i,
  input  logic                  out_ready_i,
  output logic                  out_valid_o,
  output out_word_t             out_data_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  dp_cmd_t               cmd_i,
  output dp_status_t            st_o
);

  localparam int unsigned POS_W = $clog2(TABLE_DEPTH);
  localparam int unsigned LEN_W = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned CMP_W = (LEN_W > 5) ? LEN_W : 5;

  logic [4:0]  wc_q, quorum_q, maxp_q;
  logic [15:0] timeout_q;
  logic [7:0]  thr_q;

  in_word_t    in_q;
  logic [LEN_W-1:0] len_q, scan_q;
  logic [POS_W-1:0] chk_q;
  logic [4:0]  n_q;

  logic [31:0] ent_frame_q [TABLE_DEPTH];
  logic [62:0] ent_time_q  [TABLE_DEPTH];
  logic [15:0] ent_mask_q  [TABLE_DEPTH];
  logic [4:0]  ent_count_q [TABLE_DEPTH];
  logic [15:0] ent_age_q   [TABLE_DEPTH];

  logic [7:0]  miss_q [MAX_WORKERS];
  logic [7:0]  miss_d [MAX_WORKERS];
  logic [MAX_WORKERS-1:0] alive_q, alive_d, in_range;

  logic [31:0] relcnt_q, expcnt_q;
  out_word_t   hold_q, out_q, rec, hold_last;
  logic        hold_v_q, out_v_q;

  logic [4:0]  wc_eff, active, alive_after, quorum_now;
  logic [TABLE_DEPTH-1:0] newbit, hit;
  logic [POS_W-1:0] hit_pos, rd_idx;
  logic        out_free;

  always_comb begin
    wc_eff = (wc_q > 5'(MAX_WORKERS)) ? 5'(MAX_WORKERS) : wc_q;
    for (int w = 0; w < MAX_WORKERS; w++) begin
      in_range[w] = 5'(w) < wc_eff;
    end
  end

  always_comb begin
    active      = '0;
    alive_after = '0;
    for (int w = 0; w < MAX_WORKERS; w++) begin
      active      = active + 5'(alive_q[w] & in_range[w]);
      alive_after = alive_after + 5'(alive_d[w] & in_range[w]);
    end
    quorum_now = (quorum_q < active) ? quorum_q : active;
  end

  always_comb begin
    hit_pos = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      hit[i]    = (LEN_W'(i) < len_q) && (ent_frame_q[i] == in_q.frame_number);
      newbit[i] = hit[i] && !ent_mask_q[i][in_q.worker_index];
      if (hit[i]) begin
        hit_pos = POS_W'(i);
      end
    end
  end

  always_comb begin
    case (cmd_i.rd_sel)
      RD_SCAN: rd_idx = scan_q[POS_W-1:0];
      RD_CHK:  rd_idx = chk_q;
      default: rd_idx = '0;
    endcase
  end

  always_comb begin
    for (int w = 0; w < MAX_WORKERS; w++) begin
      miss_d[w]  = miss_q[w];
      alive_d[w] = alive_q[w];
      if (in_range[w]) begin
        if (ent_mask_q[rd_idx][w]) begin
          miss_d[w]  = '0;
          alive_d[w] = 1'b1;
        end else begin
          miss_d[w] = (miss_q[w] == 8'hFF) ? miss_q[w] : miss_q[w] + 8'd1;
          if (miss_d[w] >= thr_q) begin
            alive_d[w] = 1'b0;
          end
        end
      end
    end
  end

  assign out_free = !out_v_q || out_ready_i;

  always_comb begin
    rec.out_frame         = ent_frame_q[rd_idx];
    rec.out_time          = ent_time_q[rd_idx];
    rec.contributor_mask  = ent_mask_q[rd_idx];
    rec.contributor_count = ent_count_q[rd_idx];
    rec.quorum_ok         = ent_count_q[rd_idx] >= quorum_now;
    rec.expired           = cmd_i.exp;
    rec.alive_workers     = alive_after;
    rec.released_total    = relcnt_q + 32'd1;
    rec.expired_total     = expcnt_q + 32'(cmd_i.exp);
    rec.last              = 1'b0;
  end

  always_comb begin
    hold_last      = hold_q;
    hold_last.last = 1'b1;
  end

  always_comb begin
    st_o.mode         = mode_e'(in_q.mode);
    st_o.found        = |hit;
    st_o.dup          = (|hit) && !(|newbit);
    st_o.full         = len_q == LEN_W'(TABLE_DEPTH);
    st_o.rd_met       = ent_count_q[rd_idx] >= quorum_now;
    st_o.rd_expired   = ent_age_q[rd_idx] >= timeout_q;
    st_o.scan_lt_len  = scan_q < len_q;
    st_o.over_pending = CMP_W'(len_q) > CMP_W'(maxp_q);
    st_o.len_nz       = len_q != '0;
    st_o.limit        = n_q == 5'(RESULT_LIMIT);
    st_o.hold_v       = hold_v_q;
    st_o.out_free     = out_free;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      in_q <= in_data_i;
    end
    if (cmd_i.upd) begin
      chk_q <= hit_pos;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        if (newbit[i]) begin
          ent_mask_q[i][in_q.worker_index] <= 1'b1;
          ent_count_q[i] <= ent_count_q[i] + 5'd1;
        end
      end
    end
    if (cmd_i.alloc) begin
      chk_q                           <= len_q[POS_W-1:0];
      ent_frame_q[len_q[POS_W-1:0]]   <= in_q.frame_number;
      ent_time_q[len_q[POS_W-1:0]]    <= in_q.capture_time;
      ent_mask_q[len_q[POS_W-1:0]]    <= 16'(1) << in_q.worker_index;
      ent_count_q[len_q[POS_W-1:0]]   <= 5'd1;
      ent_age_q[len_q[POS_W-1:0]]     <= '0;
    end
    if (cmd_i.age_inc) begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        if (LEN_W'(i) < len_q && ent_age_q[i] != 16'hFFFF) begin
          ent_age_q[i] <= ent_age_q[i] + 16'd1;
        end
      end
    end
    if (cmd_i.rel) begin
      for (int i = 0; i < TABLE_DEPTH - 1; i++) begin
        if (POS_W'(i) >= rd_idx) begin
          ent_frame_q[i] <= ent_frame_q[i+1];
          ent_time_q[i]  <= ent_time_q[i+1];
          ent_mask_q[i]  <= ent_mask_q[i+1];
          ent_count_q[i] <= ent_count_q[i+1];
          ent_age_q[i]   <= ent_age_q[i+1];
        end
      end
      hold_q <= rec;
    end
    if (cmd_i.rel && hold_v_q) begin
      out_q <= hold_q;
    end else if (cmd_i.push_last) begin
      out_q <= hold_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wc_q      <= 5'd16;
      quorum_q  <= 5'd16;
      timeout_q <= 16'd10;
      maxp_q    <= 5'd16;
      thr_q     <= 8'd3;
      len_q     <= '0;
      scan_q    <= '0;
      n_q       <= '0;
      relcnt_q  <= '0;
      expcnt_q  <= '0;
      hold_v_q  <= 1'b0;
      out_v_q   <= 1'b0;
      alive_q   <= '1;
      for (int w = 0; w < MAX_WORKERS; w++) begin
        miss_q[w] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_WORKER_COUNT:   wc_q      <= cfg_data_i[4:0];
          REG_QUORUM_SIZE:    quorum_q  <= cfg_data_i[4:0];
          REG_TIMEOUT_TICKS:  timeout_q <= cfg_data_i;
          REG_MAX_PENDING:    maxp_q    <= cfg_data_i[4:0];
          REG_DEAD_THRESHOLD: thr_q     <= cfg_data_i[7:0];
          default: ;
        endcase
      end
      if (cmd_i.load) begin
        n_q <= '0;
      end
      if (cmd_i.scan_clr) begin
        scan_q <= '0;
      end else if (cmd_i.scan_inc) begin
        scan_q <= scan_q + LEN_W'(1);
      end
      if (cmd_i.alloc) begin
        len_q <= len_q + LEN_W'(1);
      end
      if (cmd_i.heart && in_range[in_q.worker_index]) begin
        miss_q[in_q.worker_index]  <= '0;
        alive_q[in_q.worker_index] <= 1'b1;
      end
      if (cmd_i.rel) begin
        len_q    <= len_q - LEN_W'(1);
        n_q      <= n_q + 5'd1;
        relcnt_q <= rec.released_total;
        expcnt_q <= rec.expired_total;
        alive_q  <= alive_d;
        miss_q   <= miss_d;
        hold_v_q <= 1'b1;
      end else if (cmd_i.push_last) begin
        hold_v_q <= 1'b0;
      end
      if ((cmd_i.rel && hold_v_q) || cmd_i.push_last) begin
        out_v_q <= 1'b1;
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

endmodule

// ===== rtl/core/quorum_frame_aggregator_core.sv =====
// Top level of the frame aggregator core: joins controller and datapath.
// Depends on qfa_pkg, qfa_ctrl and qfa_datapath.
//
//  Port group    Direction  Handshake            Word
//  in            in         in_valid/in_ready    in_word_t
//  out           out        out_valid/out_ready  out_word_t
//  cfg           in         cfg_we (no wait)     index and 16-bit data
//
// One word is taken at a time. During a tick the controller visits one table
// entry per cycle, except where it stops to release an expired entry, which
// waits while the output is stalled.
// Each result leaves through a hold stage and an output register, so a stalled
// output stops the block at its next release or at the end of the word.
// The block comes out of reset idle and ready for a word.
module quorum_frame_aggregator_core import qfa_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  in_word_t              in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output out_word_t             out_data_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  dp_cmd_t    cmd;
  dp_status_t st;

  qfa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  qfa_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .st_o        (st)
  );

endmodule

// ===== rtl/core/qfa_checker.sv =====
// Port-level checks of the frame aggregator core, bound to the top level.
// Depends on qfa_pkg and quorum_frame_aggregator_core_macros.svh.
`include "quorum_frame_aggregator_core_macros.svh"

module qfa_checker import qfa_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_word_t out_data_o
);

  `QFA_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o))
  `QFA_ASSERT_NEXT(a_one_word, in_valid_i && in_ready_o, !in_ready_o)
  `QFA_ASSERT_NOW(a_count_mask, out_valid_o,
    32'(out_data_o.contributor_count) == $countones(out_data_o.contributor_mask))
  `QFA_ASSERT_NOW(a_quorum_rel, out_valid_o && !out_data_o.expired, out_data_o.quorum_ok)

endmodule

bind quorum_frame_aggregator_core qfa_checker u_qfa_checker (.*);
